@@ rtl/core/tcp_passive_handshake_tracker_unit_macros.svh @@
// Assertion macros for the connection tracker
`ifndef TCP_PASSIVE_HANDSHAKE_TRACKER_UNIT_MACROS_SVH
`define TCP_PASSIVE_HANDSHAKE_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TPH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define TPH_ASSERT(label, clk, rst_n, prop, msg)
`endif
`endif

@@ rtl/core/tph_pkg.sv @@
// Shared types and constants for the connection tracker
`timescale 1ns / 1ps
`default_nettype none
package tph_pkg;
  localparam int unsigned CONNECTIONS_DEF = 16;
  localparam logic [15:0] MAX_ECHO = 16'd1500;
  localparam logic [15:0] WORD_BYTES = 16'd4;

  localparam logic [1:0] REG_WINDOW = 2'd0;
  localparam logic [1:0] REG_SEED   = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;

  localparam logic [2:0] ST_DROP    = 3'd0;
  localparam logic [2:0] ST_SYNACK  = 3'd1;
  localparam logic [2:0] ST_ESTAB   = 3'd2;
  localparam logic [2:0] ST_DATA    = 3'd3;
  localparam logic [2:0] ST_IGNORE  = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/tph_scan.sv @@
// Entry-by-entry tuple match and free-slot search
`timescale 1ns / 1ps
`default_nettype none
module tph_scan #(
  parameter int unsigned CONNECTIONS = tph_pkg::CONNECTIONS_DEF,
  parameter int unsigned IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tph_pkg::scan_ctl_t ctl,
  input  wire logic [IW-1:0] idx,
  input  wire logic ent_valid,
  input  wire logic [95:0] ent_tuple,
  input  wire logic [95:0] key,
  output logic hit_r,
  output logic [IW-1:0] hit_idx_r,
  output logic free_r,
  output logic [IW-1:0] free_idx_r
);
  import tph_pkg::*;
  logic match;
  assign match = ent_valid && (ent_tuple == key);

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      hit_r <= 1'b0;
      free_r <= 1'b0;
      hit_idx_r <= '0;
      free_idx_r <= '0;
    end else if (ctl.step) begin
      if (match && !hit_r) begin
        hit_r <= 1'b1;
        hit_idx_r <= idx;
      end
      if (!ent_valid && !free_r) begin
        free_r <= 1'b1;
        free_idx_r <= idx;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/tcp_passive_handshake_tracker_unit.sv @@
// Top level: passive-open TCP connection tracker
// A request is handled in two steps: the tuple compare walks the connection
// table one entry per cycle in S_SCAN, then S_DONE updates the entry and
// registers the result. busy is high from acceptance until the result strobe;
// out_valid marks the result for one cycle and the receiver cannot stall it.
// Configuration writes are always taken (cfg_ready is tied high).
`timescale 1ns / 1ps
`default_nettype none
module tcp_passive_handshake_tracker_unit #(
  parameter int unsigned CONNECTIONS = tph_pkg::CONNECTIONS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [31:0] in_source_ip,
  input  wire logic [31:0] in_dest_ip,
  input  wire logic [15:0] in_source_port,
  input  wire logic [15:0] in_dest_port,
  input  wire logic [31:0] in_sequence_number,
  input  wire logic [31:0] in_ack_number,
  input  wire logic in_syn_flag,
  input  wire logic in_ack_flag,
  input  wire logic [3:0] in_header_words,
  input  wire logic [15:0] in_segment_length,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic out_valid,
  output logic [2:0] out_status,
  output logic out_send_reply,
  output logic [31:0] out_reply_source_ip,
  output logic [31:0] out_reply_dest_ip,
  output logic [15:0] out_reply_source_port,
  output logic [15:0] out_reply_dest_port,
  output logic [31:0] out_reply_sequence,
  output logic [31:0] out_reply_acknowledge,
  output logic out_reply_syn,
  output logic [15:0] out_reply_window,
  output logic [15:0] out_reply_payload_len
);
  import tph_pkg::*;
`include "tcp_passive_handshake_tracker_unit_macros.svh"
  localparam int unsigned IW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CONNECTIONS - 1);

  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r;
  logic [15:0] window_r;
  logic [31:0] step_r, isn_r;
  logic [CONNECTIONS-1:0] valid_r;
  logic [95:0] tuple_mem [CONNECTIONS];
  logic phase_mem [CONNECTIONS];
  logic [31:0] rnext_mem [CONNECTIONS];
  logic [31:0] snext_mem [CONNECTIONS];
  logic [31:0] sip_r, dip_r, seq_r, ackn_r;
  logic [15:0] sport_r, dport_r, seglen_r;
  logic [3:0] hw_r;
  logic syn_r, ackf_r;
  logic [95:0] key, ent_tuple;
  logic hit, free;
  logic [IW-1:0] hit_idx, free_idx;
  scan_ctl_t ctl;
  logic accept;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign key = {sip_r, dip_r, sport_r, dport_r};
  assign ent_tuple = tuple_mem[idx_r];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (idx_r == LAST) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.clear = accept;
    ctl.step = (state_r == S_SCAN);
  end

  tph_scan #(.CONNECTIONS(CONNECTIONS), .IW(IW)) u_scan (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .idx(idx_r),
    .ent_valid(valid_r[idx_r]), .ent_tuple(ent_tuple), .key(key),
    .hit_r(hit), .hit_idx_r(hit_idx), .free_r(free), .free_idx_r(free_idx)
  );

  // Decision for the finished scan
  logic [15:0] payload;
  logic h_phase;
  logic [31:0] h_rnext, h_snext;
  logic [2:0] st;
  logic snd, rsyn, do_alloc, do_est, do_data;
  logic [31:0] rseq, rack;
  logic [15:0] rlen;
  assign payload = seglen_r - {10'd0, hw_r, 2'b00};
  assign h_phase = phase_mem[hit_idx];
  assign h_rnext = rnext_mem[hit_idx];
  assign h_snext = snext_mem[hit_idx];

  always_comb begin
    st = ST_IGNORE; snd = 1'b0; rsyn = 1'b0;
    rseq = '0; rack = '0; rlen = '0;
    do_alloc = 1'b0; do_est = 1'b0; do_data = 1'b0;
    priority if (!hit) begin
      if (!syn_r) st = ST_DROP;
      else if (!free) st = ST_FULL;
      else begin
        st = ST_SYNACK; snd = 1'b1; rsyn = 1'b1; do_alloc = 1'b1;
        rseq = isn_r; rack = seq_r + 32'd1;
      end
    end else if (!h_phase) begin
      if (ackf_r && ackn_r == h_snext) begin
        st = ST_ESTAB; do_est = 1'b1;
      end
    end else if (seq_r == h_rnext && payload <= MAX_ECHO) begin
      st = ST_DATA; snd = 1'b1; do_data = 1'b1;
      rseq = h_snext; rack = seq_r + {16'd0, payload}; rlen = payload;
    end else begin
      st = ST_IGNORE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      valid_r <= '0;
      window_r <= 16'hFFFF;
      step_r <= 32'd64000;
      isn_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= (state_r == S_DONE);
      if (accept) idx_r <= '0;
      else if (state_r == S_SCAN && idx_r != LAST) idx_r <= idx_r + 1'b1;
      if (state_r == S_DONE && do_alloc) begin
        valid_r[free_idx] <= 1'b1;
        isn_r <= isn_r + step_r;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WINDOW: window_r <= cfg_data[15:0];
          REG_SEED:   isn_r <= cfg_data;
          REG_STEP:   step_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sip_r <= in_source_ip; dip_r <= in_dest_ip;
      sport_r <= in_source_port; dport_r <= in_dest_port;
      seq_r <= in_sequence_number; ackn_r <= in_ack_number;
      syn_r <= in_syn_flag; ackf_r <= in_ack_flag;
      hw_r <= in_header_words; seglen_r <= in_segment_length;
    end
    if (state_r == S_DONE) begin
      if (do_alloc) begin
        tuple_mem[free_idx] <= key;
        phase_mem[free_idx] <= 1'b0;
        rnext_mem[free_idx] <= seq_r + 32'd1;
        snext_mem[free_idx] <= isn_r + 32'd1;
      end
      if (do_est) phase_mem[hit_idx] <= 1'b1;
      if (do_data) begin
        rnext_mem[hit_idx] <= rack;
        snext_mem[hit_idx] <= h_snext + {16'd0, payload};
      end
      out_status <= st;
      out_send_reply <= snd;
      out_reply_source_ip <= snd ? dip_r : '0;
      out_reply_dest_ip <= snd ? sip_r : '0;
      out_reply_source_port <= snd ? dport_r : '0;
      out_reply_dest_port <= snd ? sport_r : '0;
      out_reply_sequence <= rseq;
      out_reply_acknowledge <= rack;
      out_reply_syn <= rsyn;
      out_reply_window <= snd ? window_r : '0;
      out_reply_payload_len <= rlen;
    end
  end

  `TPH_ASSERT(a_strobe_after_done, clk, rst_n, (state_r == S_DONE) |=> out_valid, "no strobe")
  `TPH_ASSERT(a_no_start_busy, clk, rst_n, accept |=> busy, "accepted but idle")
  `TPH_ASSERT(a_strobe_single, clk, rst_n, out_valid |=> !out_valid, "double strobe")
endmodule
`default_nettype wire
